[hdl/sync_length_checksum_deframer_defines.svh]
// Assertion helpers shared by the deframer modules
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, off during reset
`define SLD_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset
`define SLD_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sld_pkg.sv]
`timescale 1ns / 1ps

package sld_pkg;

	// Default longest payload
	localparam int unsigned SLD_MAX_PAYLOAD = 170;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;

	typedef enum logic [2:0] {
		PH_HUNT1   = 3'd0,
		PH_HUNT2   = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CSUM    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_CSUM_ERR = 2'd2,
		KIND_LEN_ERR  = 2'd3
	} kind_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic [7:0]  frame_length;
		logic        last;
		logic [15:0] good_frames;
		logic [15:0] checksum_errors;
		logic [15:0] length_errors;
	} res_t;

endpackage

[hdl/sld_in_if.sv]
`timescale 1ns / 1ps

// Received byte channel
interface sld_in_if ();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       clear;

	modport source (output valid, output rx_byte, output clear, input ready);
	modport sink (input valid, input rx_byte, input clear, output ready);
endinterface

[hdl/sld_out_if.sv]
`timescale 1ns / 1ps

// Result channel
interface sld_out_if import sld_pkg::*; ();
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [7:0]  payload_byte;
	logic [7:0]  byte_index;
	logic [7:0]  frame_length;
	logic        last;
	logic [15:0] good_frames;
	logic [15:0] checksum_errors;
	logic [15:0] length_errors;

	modport source (
		output valid, output kind, output payload_byte, output byte_index,
		output frame_length, output last, output good_frames,
		output checksum_errors, output length_errors, input ready
	);
	modport sink (
		input valid, input kind, input payload_byte, input byte_index,
		input frame_length, input last, input good_frames,
		input checksum_errors, input length_errors, output ready
	);
endinterface

[hdl/sync_length_checksum_deframer.sv]
// A result is registered, so it is valid in the cycle after its byte transfer.
// Throughput: one byte per cycle; a byte is taken whenever the result register
// is empty or its result is taken in the same cycle.
// Reset: arst_n clears phase, length, position, sum and counters, empties the
// result register and sets checksum checking on.
`timescale 1ns / 1ps

module sync_length_checksum_deframer import sld_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = SLD_MAX_PAYLOAD
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	sld_in_if.sink           rx,
	sld_out_if.source        tx
);

	logic accept;
	logic can_load;
	logic res_valid;
	res_t res;
	res_t res_out;

	assign rx.ready = can_load;
	assign accept   = rx.valid && can_load;

	sld_fsm #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.rx_byte   (rx.rx_byte),
		.clear     (rx.clear),
		.res_valid (res_valid),
		.res       (res)
	);

	sld_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_in    (res),
		.ready_out (tx.ready),
		.valid_out (tx.valid),
		.res_out   (res_out),
		.can_load  (can_load)
	);

	// Result fields onto the channel
	assign tx.kind            = res_out.kind;
	assign tx.payload_byte    = res_out.payload_byte;
	assign tx.byte_index      = res_out.byte_index;
	assign tx.frame_length    = res_out.frame_length;
	assign tx.last            = res_out.last;
	assign tx.good_frames     = res_out.good_frames;
	assign tx.checksum_errors = res_out.checksum_errors;
	assign tx.length_errors   = res_out.length_errors;

endmodule

[hdl/sld_fsm.sv]
`timescale 1ns / 1ps
`include "sync_length_checksum_deframer_defines.svh"

// Frame parser: phase, length, position, sum and event counters
module sld_fsm import sld_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = SLD_MAX_PAYLOAD
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  logic       clear,
	output logic       res_valid,
	output res_t       res
);

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	phase_t      phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] good_q, good_d;
	logic [15:0] csum_q, csum_d;
	logic [15:0] lerr_q, lerr_d;
	logic        verify_q;
	logic [7:0]  pos_inc;

	// Checksum check enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verify_q <= 1'b1;
		end else if (cfg_we) begin
			verify_q <= cfg_wdata;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			len_q   <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
			good_q  <= '0;
			csum_q  <= '0;
			lerr_q  <= '0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			good_q  <= good_d;
			csum_q  <= csum_d;
			lerr_q  <= lerr_d;
		end
	end

	assign pos_inc = pos_q + 8'd1;

	// Next state and result
	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		good_d    = good_q;
		csum_d    = csum_q;
		lerr_d    = lerr_q;
		res_valid = 1'b0;
		res       = '0;
		if (accept) begin
			if (clear) begin
				phase_d = PH_HUNT1;
				len_d   = '0;
				pos_d   = '0;
				sum_d   = '0;
			end else begin
				unique case (phase_q)
					PH_HUNT2: begin
						phase_d = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT1;
					end
					PH_LEN: begin
						if (rx_byte == 8'd0 || rx_byte > MaxLen) begin
							lerr_d    = (lerr_q == '1) ? lerr_q : lerr_q + 16'd1;
							phase_d   = PH_HUNT1;
							res_valid = 1'b1;
							res.kind  = KIND_LEN_ERR;
							res.last  = 1'b1;
						end else begin
							len_d   = rx_byte;
							pos_d   = '0;
							sum_d   = '0;
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						sum_d              = sum_q + rx_byte;
						pos_d              = pos_inc;
						phase_d            = (pos_inc >= len_q) ? PH_CSUM : PH_PAYLOAD;
						res_valid          = 1'b1;
						res.kind           = KIND_PAYLOAD;
						res.payload_byte   = rx_byte;
						res.byte_index     = pos_q;
						res.frame_length   = len_q;
					end
					PH_CSUM: begin
						phase_d          = PH_HUNT1;
						res_valid        = 1'b1;
						res.frame_length = len_q;
						res.last         = 1'b1;
						if (verify_q && (~sum_q != rx_byte)) begin
							csum_d   = (csum_q == '1) ? csum_q : csum_q + 16'd1;
							res.kind = KIND_CSUM_ERR;
						end else begin
							good_d   = (good_q == '1) ? good_q : good_q + 16'd1;
							res.kind = KIND_GOOD;
						end
					end
					default: begin
						// first sync hunt, unused codes too
						phase_d = (rx_byte == SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
					end
				endcase
			end
		end
		// counters after this result
		res.good_frames     = good_d;
		res.checksum_errors = csum_d;
		res.length_errors   = lerr_d;
	end

	`SLD_ASSERT_IMP(a_res_needs_xfer, clk, arst_n, res_valid, accept, "result without transfer")
	`SLD_ASSERT_IMP(a_last_kind, clk, arst_n, res_valid, res.last == (res.kind != KIND_PAYLOAD), "last flag mismatch")
	`SLD_ASSERT_IMP(a_pos_in_frame, clk, arst_n, phase_q == PH_PAYLOAD, pos_q < len_q, "payload position past length")
	`SLD_ASSERT_NXT(a_good_mono, clk, arst_n, 1'b1, good_q >= $past(good_q), "good counter went down")

endmodule

[hdl/sld_out_reg.sv]
`timescale 1ns / 1ps
`include "sync_length_checksum_deframer_defines.svh"

// Result register between parser and output channel
module sld_out_reg import sld_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic ready_out,
	output logic valid_out,
	output res_t res_out,
	output logic can_load
);

	logic valid_q;
	res_t res_q;

	// room when empty or being drained this cycle
	assign can_load  = !valid_q || ready_out;
	assign valid_out = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res_in;
		end
	end

	`SLD_ASSERT_IMP(a_no_overwrite, clk, arst_n, load, can_load, "result register overwritten")
	`SLD_ASSERT_NXT(a_hold_stall, clk, arst_n, valid_q && !ready_out, valid_q && res_q == $past(res_q), "stalled result lost")

endmodule
